@@ hdl/assert_macros.svh @@
// Assertion macros used by the search block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold on a clock edge outside reset.
`define STBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define STBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/stbs_pkg.sv @@
// Types and constants of the sorted-table binary search block.
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int IDX_W = 4;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;
  localparam int POS_W = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic idle;
    logic probing;
    logic done;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_DONE  = 3'b100
  } back_state_t;

endpackage

@@ hdl/stbs_fifo.sv @@
// Small register-based FIFO used between the block's stages.
module stbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/stbs_front.sv @@
// Input stage: accepts items, drops out-of-range loads, queues the rest.
module stbs_front #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_kind,
  input  logic [stbs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [stbs_pkg::VAL_W-1:0]   in_entry_value,
  input  logic signed [stbs_pkg::VAL_W-1:0]   in_search_key,
  input  logic                                q_full,
  output logic                                q_push,
  output stbs_pkg::item_t                     q_item
);

  logic            valid_r, valid_nxt;
  stbs_pkg::item_t item_r, item_nxt;
  stbs_pkg::op_t   op;
  logic [31:0]     idx_w;
  logic            in_range;
  logic            keep;
  logic            accept;

  assign op       = stbs_pkg::op_t'(in_kind);
  assign idx_w    = 32'(in_entry_index);
  assign in_range = (idx_w < 32'(TABLE_DEPTH));
  assign keep     = (op == stbs_pkg::OP_SEARCH) || in_range;

  // hold the staged item while the queue is full
  assign in_full = valid_r & q_full;
  assign q_push  = valid_r & ~q_full;
  assign q_item  = item_r;
  assign accept  = in_push & ~in_full;

  always_comb begin
    valid_nxt     = (accept & keep) | (valid_r & q_full);
    item_nxt.op   = op;
    item_nxt.idx  = in_entry_index;
    item_nxt.data = (op == stbs_pkg::OP_SEARCH) ? in_search_key : in_entry_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ hdl/stbs_back.sv @@
// Search engine: owns the table memory, applies loads and runs searches.
module stbs_back #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [stbs_pkg::CNT_W-1:0]   entry_count,
  input  stbs_pkg::item_t              item_i,
  input  logic                         item_empty,
  output logic                         item_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output stbs_pkg::result_t            res_data,
  output stbs_pkg::back_status_t       status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = ((AW > stbs_pkg::CNT_W) ? AW : stbs_pkg::CNT_W) + 1;
  localparam int XW = (AW > stbs_pkg::IDX_W) ? AW : stbs_pkg::IDX_W;

  logic signed [stbs_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
  logic signed [stbs_pkg::VAL_W-1:0] rd_data_r;
  logic signed [stbs_pkg::VAL_W-1:0] key_r, key_nxt;

  stbs_pkg::back_state_t state_r, state_nxt;
  logic [SW-1:0] low_r, low_nxt;
  logic [SW-1:0] hp1_r, hp1_nxt;   // one past the current high bound
  logic [SW-1:0] mid_r, mid_nxt;
  logic          found_r, found_nxt;

  logic [SW-1:0] cnt_x;
  logic [SW-1:0] dep_x;
  logic [SW-1:0] cnt_sat;
  logic [SW:0]   mid_sum;
  logic [XW-1:0] idx_x;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  assign cnt_x   = SW'(entry_count);
  assign dep_x   = SW'(TABLE_DEPTH);
  assign cnt_sat = (cnt_x > dep_x) ? dep_x : cnt_x;
  assign idx_x   = XW'(item_i.idx);
  assign wr_addr = idx_x[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    hp1_nxt   = hp1_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (!item_empty) begin
          item_pop = 1'b1;
          if (item_i.op == stbs_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            key_nxt   = item_i.data;
            low_nxt   = '0;
            hp1_nxt   = cnt_sat;
            found_nxt = 1'b0;
            state_nxt = (cnt_sat == '0) ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          state_nxt = stbs_pkg::ST_DONE;
        end else begin
          if (rd_data_r > key_r) begin
            hp1_nxt = mid_r;
          end else begin
            low_nxt = mid_r + SW'(1);
          end
          if (low_nxt >= hp1_nxt) begin
            state_nxt = stbs_pkg::ST_DONE;
          end
        end
      end
      stbs_pkg::ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
    // next probe: floor((low + high) / 2) with high = hp1 - 1
    mid_sum = {1'b0, low_nxt} + {1'b0, hp1_nxt} - (SW+1)'(1);
    if (state_nxt == stbs_pkg::ST_PROBE) begin
      mid_nxt = mid_sum[SW:1];
    end
  end

  assign rd_addr = mid_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item_i.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    hp1_r   <= hp1_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
  end

  assign res_data.found    = found_r;
  assign res_data.position = found_r ? mid_r[stbs_pkg::POS_W-1:0] : '0;

  assign status.idle    = (state_r == stbs_pkg::ST_IDLE);
  assign status.probing = (state_r == stbs_pkg::ST_PROBE);
  assign status.done    = (state_r == stbs_pkg::ST_DONE);

endmodule

@@ hdl/sorted_table_binary_search.sv @@
// Top level of the sorted-table binary search block.
// Usage:
//   Input queue (in_push / in_full): an item with in_kind low loads
//   in_entry_value at in_entry_index; an item with in_kind high searches for
//   in_search_key. Loads whose index is not below TABLE_DEPTH are dropped.
//   Result queue (out_empty / out_pop): one item per search, out_found and
//   out_position (zero when not found). Loads give no result. cfg_entry_count
//   (saturating above TABLE_DEPTH) is set via cfg_valid / cfg_ready (always
//   ready); the user must do so only with no item in flight (not enforced).
// Timing:
//   An input stage and a short item queue decouple input from the search
//   engine. The engine applies a load in its idle state; a search goes from
//   idle through P table probes (at most 5 for 16 entries), one probe per
//   cycle from the single read port of the table memory, to the done state,
//   which holds while the result queue is full and then returns to idle.
// Stalls and reset:
//   A full result queue holds the engine, then the item queue fills, then
//   in_full rises. Reset empties both queues and clears entry_count; table
//   contents are undefined until loaded.
`include "assert_macros.svh"

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = stbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_kind,
  input  logic [stbs_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [stbs_pkg::VAL_W-1:0]  in_entry_value,
  input  logic signed [stbs_pkg::VAL_W-1:0]  in_search_key,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_found,
  output logic [stbs_pkg::POS_W-1:0]         out_position,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stbs_pkg::CNT_W-1:0]         cfg_entry_count
);

  logic [stbs_pkg::CNT_W-1:0] entry_count_r;

  stbs_pkg::item_t        front_item;
  logic                   front_push;
  logic                   item_full;
  stbs_pkg::item_t        item_head;
  logic                   item_empty;
  logic                   item_pop;
  stbs_pkg::result_t      res_data;
  logic                   res_push;
  logic                   res_full;
  stbs_pkg::result_t      res_head;
  stbs_pkg::back_status_t back_st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_entry_count;
    end
  end

  stbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .q_full         (item_full),
    .q_push         (front_push),
    .q_item         (front_item)
  );

  stbs_fifo #(
    .WIDTH ($bits(stbs_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_item),
    .full  (item_full),
    .pop   (item_pop),
    .rdata (item_head),
    .empty (item_empty)
  );

  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_count (entry_count_r),
    .item_i      (item_head),
    .item_empty  (item_empty),
    .item_pop    (item_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data),
    .status      (back_st)
  );

  stbs_fifo #(
    .WIDTH ($bits(stbs_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_found    = res_head.found;
  assign out_position = res_head.position;

  `STBS_ASSERT_NEVER(a_res_no_overflow, res_push && res_full, "result pushed into full queue")
  `STBS_ASSERT_IMPL(a_pop_when_idle, item_pop, back_st.idle && !item_empty, "item taken while busy")
  `STBS_ASSERT_NEXT(a_done_retires, back_st.done && !res_full, back_st.idle, "result not retired")
  `STBS_ASSERT_IMPL(a_push_from_done, res_push, back_st.done, "result pushed outside done state")

endmodule
